>>> hw/rtl/ceq_pkg.sv
// Types and codes shared by the coalescing event queue modules.
// No dependencies.
package ceq_pkg;

   localparam int NAME_KEY_BITS = 16;

   localparam logic [1:0] KIND_PUBLISH = 2'd0;
   localparam logic [1:0] KIND_POP     = 2'd1;
   localparam logic [1:0] KIND_FLUSH   = 2'd2;

   typedef enum logic [2:0] {
      STATUS_ENQUEUED  = 3'd0,
      STATUS_COALESCED = 3'd1,
      STATUS_DROPPED   = 3'd2,
      STATUS_POPPED    = 3'd3,
      STATUS_EMPTY     = 3'd4,
      STATUS_FLUSHED   = 3'd5
   } ceq_status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        name_key;
      logic               is_telemetry;
      logic signed [31:0] payload;
      logic               flag;
   } ceq_req_type;

   typedef struct packed {
      ceq_status_type     status;
      logic [15:0]        out_name_key;
      logic               out_class;
      logic signed [31:0] out_payload;
      logic               out_flag;
   } ceq_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_READ,
      ST_POP_VALUE
   } ceq_state_type;

   typedef struct packed {
      logic alloc;
      logic set_pend;
      logic clr_pend;
      logic clr_all;
   } ceq_track_cmd_type;

   typedef struct packed {
      logic hit;
      logic hit_pend;
      logic full;
   } ceq_track_stat_type;

endpackage

>>> hw/rtl/ceq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ceq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ceq_track.sv
// Telemetry tracking table: name keys, pending marks, allocation count, key match.
// Depends on ceq_pkg.
module ceq_track #(
   parameter int SLOTS = 8,
   parameter int KW = 16,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [KW-1:0]               lk_key,
   input  ceq_pkg::ceq_track_cmd_type  cmd,
   input  logic [SW-1:0]               cmd_slot,
   output ceq_pkg::ceq_track_stat_type stat,
   output logic [SW-1:0]               hit_slot,
   output logic [SW-1:0]               free_slot
);

   import ceq_pkg::*;

   localparam int UW = $clog2(SLOTS + 1);

   logic [KW-1:0]    keys_ff [SLOTS];
   logic [SLOTS-1:0] pend_ff;
   logic [SLOTS-1:0] pend_in;
   logic [UW-1:0]    used_ff;
   logic [UW-1:0]    used_in;
   logic [SLOTS-1:0] match;
   logic [SW-1:0]    hit_slot_c;
   logic             full;

   always_comb begin
      match      = '0;
      hit_slot_c = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = (UW'(i) < used_ff) && (keys_ff[i] == lk_key);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_slot_c = SW'(i);
         end
      end
   end

   assign full          = (used_ff == UW'(SLOTS));
   assign stat.hit      = |match;
   assign stat.hit_pend = pend_ff[hit_slot_c];
   assign stat.full     = full;
   assign hit_slot      = hit_slot_c;
   assign free_slot     = used_ff[SW-1:0];

   always_comb begin
      pend_in = pend_ff;
      used_in = used_ff;
      priority if (cmd.clr_all) begin
         pend_in = '0;
      end else if (cmd.set_pend) begin
         pend_in[cmd_slot] = 1'b1;
      end else if (cmd.clr_pend) begin
         pend_in[cmd_slot] = 1'b0;
      end
      if (cmd.alloc && !full) begin
         used_in = used_ff + UW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         used_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc && !full) begin
         keys_ff[used_ff[SW-1:0]] <= lk_key;
      end
   end

endmodule

>>> hw/rtl/coalescing_event_queue_core.sv
// Coalescing event queue top level: control sequencer, FIFO pointers, result register.
// Depends on ceq_pkg, ceq_ram and ceq_track.
//
//  channel | ports                          | carries
//  req     | req_valid req_ready req_item   | ceq_req_type: publish, pop or flush
//  rsp     | rsp_valid rsp_ready rsp_item   | ceq_rsp_type: one status per valid kind
//
// One item at a time; a new item is taken only in idle. Publish, flush and empty
// pop: result registered from the execute step. Pop of a state or untracked entry:
// execute, then entry RAM read. Pop of a tracked telemetry entry: execute, entry RAM
// read, then tracked value RAM read. Unused kind gives no result.
// Reset clears pointers, fill, pending marks and slot count.
// A pending result stalls only the execute step; req is taken in idle.
module coalescing_event_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TRACK_SLOTS = 8,
   parameter int KEY_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ceq_pkg::ceq_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ceq_pkg::ceq_rsp_type rsp_item
);

   import ceq_pkg::*;

   localparam int KW = (KEY_WIDTH < NAME_KEY_BITS) ? KEY_WIDTH : NAME_KEY_BITS;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
   localparam int EW = KW + 34;

   ceq_state_type      state_ff, state_in;
   ceq_req_type        item_ff;
   ceq_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [QW-1:0]      head_ff, head_in;
   logic [QW-1:0]      tail_ff, tail_in;
   logic [FW-1:0]      fill_ff, fill_in;

   logic               fifo_we, fifo_re;
   logic [EW-1:0]      fifo_wdata, fifo_rd;
   logic               val_we, val_re;
   logic [31:0]        val_rd;

   ceq_track_cmd_type  cmd;
   ceq_track_stat_type stat;
   logic [SW-1:0]      cmd_slot, hit_slot, free_slot, pub_slot;
   logic [KW-1:0]      item_key, rd_key, lk_key;
   logic               rd_cls, rd_flag;
   logic [31:0]        rd_val;
   logic               out_free, fifo_full, fifo_empty;
   logic               coal, tracked;

   assign item_key   = item_ff.name_key[KW-1:0];
   assign rd_key     = fifo_rd[EW-1 -: KW];
   assign rd_cls     = fifo_rd[33];
   assign rd_val     = fifo_rd[32:1];
   assign rd_flag    = fifo_rd[0];
   assign fifo_wdata = {item_key, item_ff.is_telemetry, item_ff.payload, item_ff.flag};
   assign lk_key     = (state_ff == ST_EXEC) ? item_key : rd_key;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fifo_full  = (fill_ff == FW'(QUEUE_DEPTH));
   assign fifo_empty = (fill_ff == '0);
   assign coal       = item_ff.is_telemetry && stat.hit && stat.hit_pend;
   assign tracked    = item_ff.is_telemetry && (stat.hit || !stat.full);
   assign pub_slot   = stat.hit ? hit_slot : free_slot;
   assign cmd_slot   = (state_ff == ST_EXEC) ? pub_slot : hit_slot;

   ceq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (fifo_wdata),
      .rd_en   (fifo_re),
      .rd_addr (head_ff),
      .rd_data (fifo_rd)
   );

   ceq_ram #(.WIDTH(32), .DEPTH(TRACK_SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (pub_slot),
      .wr_data (item_ff.payload),
      .rd_en   (val_re),
      .rd_addr (hit_slot),
      .rd_data (val_rd)
   );

   ceq_track #(.SLOTS(TRACK_SLOTS), .KW(KW)) u_track (
      .clock     (clock),
      .reset     (reset),
      .lk_key    (lk_key),
      .cmd       (cmd),
      .cmd_slot  (cmd_slot),
      .stat      (stat),
      .hit_slot  (hit_slot),
      .free_slot (free_slot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               if (item_ff.kind == KIND_POP && !fifo_empty) begin
                  state_in = ST_POP_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POP_READ: begin
            if (rd_cls && stat.hit) begin
               state_in = ST_POP_VALUE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_VALUE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      fifo_we      = 1'b0;
      fifo_re      = 1'b0;
      val_we       = 1'b0;
      val_re       = 1'b0;
      cmd          = '0;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            if (out_free) begin
               unique case (item_ff.kind)
                  KIND_PUBLISH: begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                     if (coal) begin
                        val_we        = 1'b1;
                        rsp_in.status = STATUS_COALESCED;
                     end else begin
                        if (tracked) begin
                           val_we       = 1'b1;
                           cmd.alloc    = !stat.hit;
                           cmd.set_pend = !fifo_full;
                        end
                        if (fifo_full) begin
                           rsp_in.status = STATUS_DROPPED;
                        end else begin
                           fifo_we       = 1'b1;
                           tail_in       = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 :
                                           tail_ff + QW'(1);
                           fill_in       = fill_ff + FW'(1);
                           rsp_in.status = STATUS_ENQUEUED;
                        end
                     end
                  end
                  KIND_POP: begin
                     if (fifo_empty) begin
                        rsp_in        = '0;
                        rsp_in.status = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        fifo_re = 1'b1;
                        head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QW'(1);
                        fill_in = fill_ff - FW'(1);
                     end
                  end
                  KIND_FLUSH: begin
                     head_in       = '0;
                     tail_in       = '0;
                     fill_in       = '0;
                     cmd.clr_all   = 1'b1;
                     rsp_in        = '0;
                     rsp_in.status = STATUS_FLUSHED;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP_READ: begin
            if (rd_cls && stat.hit) begin
               val_re = 1'b1;
            end else begin
               rsp_in.status       = STATUS_POPPED;
               rsp_in.out_name_key = NAME_KEY_BITS'(rd_key);
               rsp_in.out_class    = rd_cls;
               rsp_in.out_payload  = rd_val;
               rsp_in.out_flag     = rd_flag;
               rsp_valid_in        = 1'b1;
            end
         end
         ST_POP_VALUE: begin
            cmd.clr_pend        = 1'b1;
            rsp_in.status       = STATUS_POPPED;
            rsp_in.out_name_key = NAME_KEY_BITS'(rd_key);
            rsp_in.out_class    = rd_cls;
            rsp_in.out_payload  = val_rd;
            rsp_in.out_flag     = rd_flag;
            rsp_valid_in        = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("fifo fill above depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == FW'(QUEUE_DEPTH)) |-> (head_ff == tail_ff))
      else $error("fifo pointers disagree with fill");

   a_pop_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_READ || state_ff == ST_POP_VALUE) |-> !rsp_valid_ff)
      else $error("pop in progress while result register occupied");

   a_exec_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for coalescing_event_queue_core: directed then random event traffic,
// a local model of the FIFO and tracking table, random idling on both channels.
// Depends on ceq_pkg and the coalescing_event_queue_core RTL.
module testbench;
   import ceq_pkg::*;

   localparam int DEPTH = 16;
   localparam int SLOTS = 8;
   localparam int RANDOM_ITEMS = 1550;
   localparam int QUIET_TAIL = 150;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ceq_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ceq_rsp_type rsp_item;

   coalescing_event_queue_core #(
      .QUEUE_DEPTH(DEPTH),
      .TRACK_SLOTS(SLOTS),
      .KEY_WIDTH(NAME_KEY_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item)
   );

   always #2 clock = ~clock;

   ceq_req_type pending_events[$];
   bit          drain_before[$];
   ceq_rsp_type expected_rsps[$];
   int          errors = 0;

   // model of the queue and tracking table
   ceq_req_type        fifo_mem[DEPTH];
   logic [3:0]         fifo_rd;
   logic [3:0]         fifo_wr;
   int                 fifo_count;
   logic [15:0]        slot_key[SLOTS];
   logic signed [31:0] slot_value[SLOTS];
   bit                 slot_pending[SLOTS];
   int                 slots_used;

   function automatic int find_slot(logic [15:0] key);
      for (int i = 0; i < slots_used; i++)
         if (slot_key[i] == key) return i;
      return -1;
   endfunction

   task automatic predict_event(ceq_req_type ev);
      ceq_rsp_type r;
      ceq_req_type head;
      int          idx;
      r = '0;
      idx = -1;
      if (ev.kind == KIND_PUBLISH) begin
         if (ev.is_telemetry) begin
            idx = find_slot(ev.name_key);
            if (idx >= 0 && slot_pending[idx]) begin
               slot_value[idx] = ev.payload;
               r.status = STATUS_COALESCED;
               expected_rsps.push_back(r);
               return;
            end
            if (idx < 0 && slots_used < SLOTS) begin
               idx = slots_used;
               slot_key[idx] = ev.name_key;
               slots_used++;
            end
            if (idx >= 0) begin
               slot_pending[idx] = 1'b1;
               slot_value[idx] = ev.payload;
            end
         end
         if (fifo_count >= DEPTH) begin
            if (idx >= 0) slot_pending[idx] = 1'b0;
            r.status = STATUS_DROPPED;
         end else begin
            fifo_mem[fifo_wr] = ev;
            fifo_wr++;
            fifo_count++;
            r.status = STATUS_ENQUEUED;
         end
         expected_rsps.push_back(r);
      end else if (ev.kind == KIND_POP) begin
         if (fifo_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            head = fifo_mem[fifo_rd];
            fifo_rd++;
            fifo_count--;
            r.status = STATUS_POPPED;
            r.out_name_key = head.name_key;
            r.out_class = head.is_telemetry;
            r.out_payload = head.payload;
            r.out_flag = head.flag;
            if (head.is_telemetry) begin
               idx = find_slot(head.name_key);
               if (idx >= 0) begin
                  r.out_payload = slot_value[idx];
                  slot_pending[idx] = 1'b0;
               end
            end
         end
         expected_rsps.push_back(r);
      end else if (ev.kind == KIND_FLUSH) begin
         fifo_rd = '0;
         fifo_wr = '0;
         fifo_count = 0;
         for (int i = 0; i < SLOTS; i++) slot_pending[i] = 1'b0;
         r.status = STATUS_FLUSHED;
         expected_rsps.push_back(r);
      end
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   // driver
   int  gap_left = 0;
   bit  took;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && req_ready;
         if (took) predict_event(req_item);
         if (took || !req_valid) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_events.size() > 0 &&
                         !(drain_before[0] && expected_rsps.size() > 0)) begin
               req_item <= pending_events.pop_front();
               void'(drain_before.pop_front());
               req_valid <= 1'b1;
               if (pending_events.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0)
                  gap_left = $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int          stall_left = 0;
   ceq_rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual status %0d",
                        $time, rsp_item.status);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_item.status));
               check_field("out_name_key", 32'(want.out_name_key), 32'(rsp_item.out_name_key));
               check_field("out_class", 32'(want.out_class), 32'(rsp_item.out_class));
               check_field("out_payload", want.out_payload, rsp_item.out_payload);
               check_field("out_flag", 32'(want.out_flag), 32'(rsp_item.out_flag));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (pending_events.size() >= QUIET_TAIL && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic add_event(logic [1:0] kind, logic [15:0] key, logic cls,
                            logic [31:0] value, logic flag, bit drain = 1'b0);
      ceq_req_type ev;
      ev.kind = kind;
      ev.name_key = key;
      ev.is_telemetry = cls;
      ev.payload = value;
      ev.flag = flag;
      pending_events.push_back(ev);
      drain_before.push_back(drain);
   endtask

   function automatic logic [15:0] pick_key();
      if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 11));
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      int count;
      int burst;
      bit drained;
      logic [15:0] key;

      fifo_rd = '0;
      fifo_wr = '0;
      fifo_count = 0;
      slots_used = 0;
      for (int i = 0; i < SLOTS; i++) slot_pending[i] = 1'b0;

      // directed: empty pop, extremes, coalescing, unused kind, full FIFO, flush
      add_event(KIND_POP, 16'h0000, 1'b0, 32'h0, 1'b0);
      add_event(KIND_PUBLISH, 16'h0000, 1'b0, 32'h8000_0000, 1'b0);
      add_event(KIND_PUBLISH, 16'hFFFF, 1'b1, 32'h7FFF_FFFF, 1'b1);
      add_event(KIND_PUBLISH, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
      add_event(KIND_UNUSED, 16'h1234, 1'b1, 32'h5555_5555, 1'b1);
      add_event(KIND_POP, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
      add_event(KIND_POP, 16'h0000, 1'b0, 32'h0, 1'b0);
      add_event(KIND_PUBLISH, 16'h00A5, 1'b1, 32'h0000_0001, 1'b1);
      for (int i = 0; i < DEPTH - 1; i++)
         add_event(KIND_PUBLISH, 16'(i), 1'b0, $urandom, 1'($urandom));
      add_event(KIND_PUBLISH, 16'h005A, 1'b1, 32'h1357_9BDF, 1'b1);
      add_event(KIND_PUBLISH, 16'h00A5, 1'b1, 32'hDEAD_BEEF, 1'b0);
      add_event(KIND_PUBLISH, 16'h0033, 1'b0, 32'h0, 1'b1);
      add_event(KIND_FLUSH, 16'h0000, 1'b0, 32'h0, 1'b0);
      add_event(KIND_POP, 16'h0000, 1'b0, 32'h0, 1'b0);

      count = 0;
      drained = 1'b0;
      while (count < RANDOM_ITEMS) begin
         burst = $urandom_range(0, 99);
         if (burst < 45) begin
            repeat ($urandom_range(1, 20)) begin
               add_event(KIND_PUBLISH, pick_key(), 1'($urandom_range(0, 2) != 0),
                         $urandom, 1'($urandom), !drained && count > RANDOM_ITEMS / 2);
               if (count > RANDOM_ITEMS / 2) drained = 1'b1;
               count++;
            end
         end else if (burst < 78) begin
            repeat ($urandom_range(1, 18)) begin
               add_event(KIND_POP, 16'($urandom), 1'($urandom), $urandom, 1'($urandom));
               count++;
            end
         end else if (burst < 86) begin
            add_event(KIND_FLUSH, 16'($urandom), 1'($urandom), $urandom, 1'($urandom));
            count++;
         end else if (burst < 93) begin
            add_event(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom),
                      $urandom, 1'($urandom));
            if (pending_events[$].kind != KIND_UNUSED) count++;
         end else begin
            key = pick_key();
            repeat ($urandom_range(1, 6)) begin
               add_event(KIND_PUBLISH, key, 1'b1, $urandom, 1'($urandom));
               add_event(KIND_POP, 16'h0, 1'b0, 32'h0, 1'b0);
               count += 2;
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_events.size() > 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
